[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CPSO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CPSO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cpso_pkg.sv]
// ---------------------------------------------------------------------------
// cpso_pkg
// Shared widths, defaults and the contour descriptor type.
// ---------------------------------------------------------------------------
package cpso_pkg;

  // Default contour capacity in points.
  localparam int unsigned MAX_POINTS_DEF = 32;
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned PT_W           = 2 * COORD_W;
  // Width of a point count; holds counts up to 63.
  localparam int unsigned CNT_W          = 6;

  typedef logic [PT_W-1:0] point_t;

  // One finished contour, handed from the loader to the emitter.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             later;
    point_t           first;
  } contour_desc_t;

endpackage

[design/cpso_front.sv]
// ---------------------------------------------------------------------------
// cpso_front
// Point loader: writes points into the free contour bank, detects the
// closing point and posts a descriptor for each finished contour.
// ---------------------------------------------------------------------------
module cpso_front #(
  parameter int unsigned MAX_POINTS = cpso_pkg::MAX_POINTS_DEF,
  localparam int unsigned IW = $clog2(MAX_POINTS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [31:0]             in_point_x,
  input  logic [31:0]             in_point_y,
  input  logic                    in_contour_end,
  input  logic                    in_path_end,
  output logic                    wr_en,
  output logic                    wr_bank,
  output logic [IW-1:0]           wr_idx,
  output cpso_pkg::point_t        wr_data,
  output logic                    desc_push,
  output cpso_pkg::contour_desc_t desc,
  input  logic                    retire
);
  import cpso_pkg::*;

  localparam logic [1:0] NUM_BANKS = 2'd2;

  logic [CNT_W-1:0] cnt_r;
  logic             later_r;
  logic             wbank_r;
  logic [1:0]       out_cnt_r;
  logic [1:0]       out_cnt_nxt;
  point_t           first_r;
  point_t           last_r;

  logic             accept;
  logic             room;
  point_t           pt;
  point_t           first_eff;
  point_t           last_eff;
  logic [CNT_W-1:0] n_raw;
  logic [CNT_W-1:0] n_eff;

  // A beat is taken only while a bank is free for loading.
  assign full   = (out_cnt_r == NUM_BANKS);
  assign accept = push && !full;
  assign room   = (cnt_r < CNT_W'(MAX_POINTS));
  assign pt     = {in_point_x, in_point_y};

  // Store write port; points beyond the capacity are discarded.
  assign wr_en   = accept && room;
  assign wr_bank = wbank_r;
  assign wr_idx  = cnt_r[IW-1:0];
  assign wr_data = pt;

  // Closing test on the contour as it stands after this beat.
  always_comb begin
    first_eff = (cnt_r == '0) ? pt : first_r;
    last_eff  = room ? pt : last_r;
    n_raw     = room ? (cnt_r + CNT_W'(1)) : cnt_r;
    if ((n_raw > CNT_W'(1)) && (last_eff == first_eff)) begin
      n_eff = n_raw - CNT_W'(1);
    end else begin
      n_eff = n_raw;
    end
  end

  assign desc_push   = accept && in_contour_end;
  assign desc.n      = n_eff;
  assign desc.later  = later_r;
  assign desc.first  = first_eff;

  // Contours loaded but not yet fully issued by the emitter.
  assign out_cnt_nxt = out_cnt_r + {1'b0, desc_push} - {1'b0, retire};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      later_r   <= 1'b0;
      wbank_r   <= 1'b0;
      out_cnt_r <= '0;
    end else begin
      out_cnt_r <= out_cnt_nxt;
      if (accept) begin
        if (in_contour_end) begin
          cnt_r   <= '0;
          later_r <= !in_path_end;
          wbank_r <= ~wbank_r;
        end else if (room) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // First and most recent stored point of the open contour.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_r <= pt;
      if (cnt_r == '0) begin
        first_r <= pt;
      end
    end
  end

endmodule

[design/cpso_desc_queue.sv]
// ---------------------------------------------------------------------------
// cpso_desc_queue
// Two-entry queue of finished contour descriptors between loader and
// emitter.
// ---------------------------------------------------------------------------
module cpso_desc_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  cpso_pkg::contour_desc_t din,
  input  logic                    pop,
  output logic                    empty,
  output cpso_pkg::contour_desc_t dout
);
  import cpso_pkg::*;

  contour_desc_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign dout  = ent_r[rd_ptr_r];

  // Pointers and fill level; the loader never posts more than two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

[design/cpso_back.sv]
// ---------------------------------------------------------------------------
// cpso_back
// Strip emitter: holds the two contour banks, walks each finished contour
// front and back alternately and queues the strip vertices for output.
// ---------------------------------------------------------------------------
module cpso_back #(
  parameter int unsigned MAX_POINTS = cpso_pkg::MAX_POINTS_DEF,
  localparam int unsigned IW = $clog2(MAX_POINTS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic                    wr_bank,
  input  logic [IW-1:0]           wr_idx,
  input  cpso_pkg::point_t        wr_data,
  input  logic                    desc_empty,
  input  cpso_pkg::contour_desc_t desc,
  output logic                    desc_pop,
  output logic                    retire,
  output logic [31:0]             out_vertex_x,
  output logic [31:0]             out_vertex_y,
  output logic                    out_run_last,
  output logic                    empty,
  input  logic                    pop
);
  import cpso_pkg::*;

  // Emission phases.
  localparam logic [1:0] PH_PREV  = 2'd0;
  localparam logic [1:0] PH_BRK   = 2'd1;
  localparam logic [1:0] PH_FIRST = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  // Source of a vertex in flight.
  localparam logic [1:0] KIND_MEM  = 2'd0;
  localparam logic [1:0] KIND_FIX  = 2'd1;
  localparam logic [1:0] KIND_PREV = 2'd2;

  localparam logic [2:0] OF_DEPTH = 3'd4;

  typedef struct packed {
    point_t pt;
    logic   last;
  } vertex_ent_t;

  // Contour banks.
  point_t mem_r [2][MAX_POINTS];
  point_t rd_data_r;

  // Sequencer state.
  logic             busy_r, busy_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             side_r, side_nxt;
  logic [IW-1:0]    a_r, a_nxt;
  logic [IW-1:0]    b_r, b_nxt;
  logic             rbank_r, rbank_nxt;
  logic [CNT_W-1:0] n_r;
  point_t           first_r;
  point_t           prev_r;

  // Read stage.
  logic             s1_valid_r;
  logic [1:0]       s1_kind_r;
  logic             s1_last_r;
  point_t           s1_fixed_r;

  // Output queue.
  vertex_ent_t      of_mem_r [4];
  logic [1:0]       of_wr_ptr_r;
  logic [1:0]       of_rd_ptr_r;
  logic [2:0]       of_cnt_r;

  logic             space;
  logic             issue;
  logic             done;
  logic             rd_en;
  logic [IW-1:0]    rd_idx;
  logic [1:0]       iss_kind;
  logic             iss_last;
  logic [CNT_W-1:0] n_m1;
  logic [IW:0]      a_inc;
  logic             of_pop;
  point_t           wdata;

  // Room in the output queue counting the vertex still in the read stage.
  assign space = ((of_cnt_r + {2'b0, s1_valid_r}) < OF_DEPTH);
  assign issue = busy_r && space;
  assign n_m1  = n_r - CNT_W'(1);
  assign a_inc = {1'b0, a_r} + (IW+1)'(1);

  // Strip sequencer: break, first point, then front/back pairs and middle.
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    side_nxt  = side_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    rbank_nxt = rbank_r;
    iss_kind  = KIND_FIX;
    iss_last  = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = a_r;
    done      = 1'b0;
    desc_pop  = 1'b0;
    if (!busy_r) begin
      if (!desc_empty) begin
        desc_pop  = 1'b1;
        busy_nxt  = 1'b1;
        phase_nxt = desc.later ? PH_PREV : PH_FIRST;
      end
    end else if (space) begin
      case (phase_r)
        PH_PREV: begin
          iss_kind  = KIND_PREV;
          phase_nxt = PH_BRK;
        end
        PH_BRK: begin
          phase_nxt = PH_FIRST;
        end
        PH_FIRST: begin
          if (n_r == CNT_W'(1)) begin
            iss_last = 1'b1;
            done     = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
            a_nxt     = IW'(1);
            b_nxt     = n_m1[IW-1:0];
            side_nxt  = 1'b0;
          end
        end
        PH_BODY: begin
          iss_kind = KIND_MEM;
          rd_en    = 1'b1;
          if (a_r == b_r) begin
            // Middle point left over.
            iss_last = 1'b1;
            done     = 1'b1;
          end else if (!side_r) begin
            side_nxt = 1'b1;
          end else begin
            rd_idx   = b_r;
            iss_last = (a_inc >= {1'b0, b_r});
            a_nxt    = a_r + IW'(1);
            b_nxt    = b_r - IW'(1);
            side_nxt = 1'b0;
            done     = iss_last;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    if (done) begin
      busy_nxt  = 1'b0;
      rbank_nxt = ~rbank_r;
    end
  end

  // The bank is free as soon as its last read has issued.
  assign retire = done;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      phase_r    <= PH_FIRST;
      side_r     <= 1'b0;
      a_r        <= '0;
      b_r        <= '0;
      rbank_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      phase_r    <= phase_nxt;
      side_r     <= side_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      rbank_r    <= rbank_nxt;
      s1_valid_r <= issue;
    end
  end

  // Descriptor payload and read-stage payload.
  always_ff @(posedge clk) begin
    if (desc_pop) begin
      n_r     <= desc.n;
      first_r <= desc.first;
    end
    if (issue) begin
      s1_kind_r  <= iss_kind;
      s1_last_r  <= iss_last;
      s1_fixed_r <= first_r;
    end
  end

  // Bank memory: one write port from the loader, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_bank][wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rbank_r][rd_idx];
    end
  end

  // Vertex selection; the break vertex reads the last vertex already queued.
  always_comb begin
    case (s1_kind_r)
      KIND_MEM:  wdata = rd_data_r;
      KIND_PREV: wdata = prev_r;
      default:   wdata = s1_fixed_r;
    endcase
  end

  // Last vertex of each contour is remembered for the next break.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (s1_valid_r && s1_last_r) begin
      prev_r <= wdata;
    end
  end

  // Output queue.
  assign empty  = (of_cnt_r == 3'd0);
  assign of_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_ptr_r <= '0;
      of_rd_ptr_r <= '0;
      of_cnt_r    <= '0;
    end else begin
      if (s1_valid_r) begin
        of_wr_ptr_r <= of_wr_ptr_r + 2'd1;
      end
      if (of_pop) begin
        of_rd_ptr_r <= of_rd_ptr_r + 2'd1;
      end
      of_cnt_r <= of_cnt_r + {2'b0, s1_valid_r} - {2'b0, of_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      of_mem_r[of_wr_ptr_r] <= '{pt: wdata, last: s1_last_r};
    end
  end

  assign out_vertex_x = of_mem_r[of_rd_ptr_r].pt[PT_W-1:COORD_W];
  assign out_vertex_y = of_mem_r[of_rd_ptr_r].pt[COORD_W-1:0];
  assign out_run_last = of_mem_r[of_rd_ptr_r].last;

endmodule

[design/convex_polygon_strip_order_unit.sv]
// ---------------------------------------------------------------------------
// convex_polygon_strip_order_unit
// Reorders each convex contour of a path into a triangle strip. Points are
// taken at one beat per cycle while full is low into one of two contour
// banks; a finished contour is emitted at one vertex per cycle, while the
// output queue has room, from the other bank, so loading and emitting
// overlap. A contour of n stored points emits about n vertices (the closing
// point is dropped when it repeats the first), plus two break vertices (the
// previous vertex and a repeat of the first point) for every contour after
// the first of a path; the emitter's single bank read port sets this one
// vertex per cycle, and no vertex issues while a contour's descriptor is
// taken.
// full rises while both banks hold finished contours not yet fully issued,
// and results are buffered in a four-deep output queue.
// ---------------------------------------------------------------------------
module convex_polygon_strip_order_unit #(
  parameter int unsigned MAX_POINTS = cpso_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic        in_contour_end,
  input  logic        in_path_end,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_vertex_x,
  output logic [31:0] out_vertex_y,
  output logic        out_run_last
);
  import cpso_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);

  logic          wr_en;
  logic          wr_bank;
  logic [IW-1:0] wr_idx;
  point_t        wr_data;
  logic          desc_push;
  contour_desc_t desc_in;
  logic          desc_pop;
  logic          desc_empty;
  contour_desc_t desc_out;
  logic          retire;

  // Loader.
  cpso_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_contour_end (in_contour_end),
    .in_path_end    (in_path_end),
    .wr_en          (wr_en),
    .wr_bank        (wr_bank),
    .wr_idx         (wr_idx),
    .wr_data        (wr_data),
    .desc_push      (desc_push),
    .desc           (desc_in),
    .retire         (retire)
  );

  // Descriptor queue.
  cpso_desc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .din   (desc_in),
    .pop   (desc_pop),
    .empty (desc_empty),
    .dout  (desc_out)
  );

  // Emitter.
  cpso_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_bank      (wr_bank),
    .wr_idx       (wr_idx),
    .wr_data      (wr_data),
    .desc_empty   (desc_empty),
    .desc         (desc_out),
    .desc_pop     (desc_pop),
    .retire       (retire),
    .out_vertex_x (out_vertex_x),
    .out_vertex_y (out_vertex_y),
    .out_run_last (out_run_last),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

[design/cpso_checker.sv]
// ---------------------------------------------------------------------------
// cpso_checker
// Port-level checks on the strip orderer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpso_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        in_contour_end,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_vertex_x,
  input logic [31:0] out_vertex_y,
  input logic        out_run_last
);

  logic [3:0] pend_r;
  logic       end_beat;
  logic       last_beat;

  // Contours closed at the input whose final vertex has not yet left.
  assign end_beat  = push && !full && in_contour_end;
  assign last_beat = pop && !empty && out_run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {3'b0, end_beat} - {3'b0, last_beat};
    end
  end

  // A waiting result stays put until it is taken.
  `CPSO_ASSERT_NXT(a_out_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_vertex_x) && $stable(out_vertex_y) && $stable(out_run_last), "result changed while waiting")

  // Results only belong to contours already closed.
  `CPSO_ASSERT_IMP(a_no_spurious, clk, rst_n, !empty, pend_r != 4'd0, "result without a closed contour")

  // The input stalls only with both banks holding finished contours.
  `CPSO_ASSERT_IMP(a_full_pending, clk, rst_n, full, pend_r >= 4'd2, "input stalled without two contours pending")

endmodule

bind convex_polygon_strip_order_unit cpso_checker u_cpso_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .in_contour_end (in_contour_end),
  .empty          (empty),
  .pop            (pop),
  .out_vertex_x   (out_vertex_x),
  .out_vertex_y   (out_vertex_y),
  .out_run_last   (out_run_last)
);
